// ----- rtl/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the one-wire bus master
// Item layouts, request codes, the one-hot phase encoding, the register
// block layout and the tick-count saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // Tick counter width and largest count it holds
  localparam int COUNT_WIDTH    = 10;
  localparam int CNT_MAX_I      = (1 << COUNT_WIDTH) - 1;
  localparam int BYTE_GAP_TICKS = 5;
  localparam int GAP_LEN_I      = (BYTE_GAP_TICKS > CNT_MAX_I) ? CNT_MAX_I : BYTE_GAP_TICKS;
  localparam int READ_LOW_TICKS  = 2;
  localparam int READ_WAIT_TICKS = 2;

  localparam int REG_W    = 10;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam cnt_t CNT_MAX       = cnt_t'(CNT_MAX_I);
  localparam cnt_t GAP_LEN       = cnt_t'(GAP_LEN_I);
  localparam cnt_t READ_LOW_LEN  = cnt_t'(READ_LOW_TICKS);
  localparam cnt_t READ_WAIT_LEN = cnt_t'(READ_WAIT_TICKS);

  // Request codes
  localparam logic [1:0] REQ_RESET = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRES_TMO    = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESET_TAIL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WR1_LOW     = 3'd3;
  localparam logic [IDX_W-1:0] REG_WR1_HIGH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_WR0_LOW     = 3'd5;
  localparam logic [IDX_W-1:0] REG_WR0_HIGH    = 3'd6;
  localparam logic [IDX_W-1:0] REG_RD_RECOVERY = 3'd7;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_WR_LOW   = 10'b00_0001_0000,
    PH_WR_HIGH  = 10'b00_0010_0000,
    PH_WR_GAP   = 10'b00_0100_0000,
    PH_RD_LOW   = 10'b00_1000_0000,
    PH_RD_WAIT  = 10'b01_0000_0000,
    PH_RD_REC   = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] write_data;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] reset_low_ticks;
    logic [REG_W-1:0] presence_timeout_ticks;
    logic [REG_W-1:0] reset_tail_ticks;
    logic [REG_W-1:0] write_one_low_ticks;
    logic [REG_W-1:0] write_one_high_ticks;
    logic [REG_W-1:0] write_zero_low_ticks;
    logic [REG_W-1:0] write_zero_high_ticks;
    logic [REG_W-1:0] read_recovery_ticks;
  } cfg_t;

  // Clamp a register length to what the tick counter can hold
  function automatic cnt_t sat_len(input logic [REG_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(CNT_MAX_I)) begin
      return CNT_MAX;
    end
    return wide[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/one_wire_bus_master.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master: open-drain single-wire bus master
// Runs reset/presence, byte write and byte read slots from a stream of
// command and one-microsecond tick words.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* carries one word per item: a command (reset, write byte, read
//    byte) or a tick with the sampled bus level. Commands are only started
//    while idle; a command during an operation comes back with rejected set.
//  - out_* returns exactly one result word per input word: drive level for
//    the next tick, busy, done pulse, presence and the last read byte.
//  - cfg_* writes the eight timing registers; it is always ready. Write only
//    while no words are in flight.
//  - An accepted word waits in the input register, then the sequencer
//    updates its state and loads the output register. Throughput is one
//    word per cycle while out_ready does not stall; the sequencer does all
//    phase bookkeeping for a word in a single pass.
//  - A stalled out_ready holds the result register; the input register takes
//    one more word, then in_ready drops until the output drains.
//  - Synchronous reset returns to idle, clears presence and the read byte and
//    reloads the default timing values.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master
  import owbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;
  out_item_t res;
  logic      adv;

  // Move a word into the sequencer when the output register is free
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  owbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owbm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/owbm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// owbm_cfg_regs: timing register block
// Eight 10-bit phase lengths, written through a valid/ready port that is
// always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks        <= 10'd490;
      cfg_r.presence_timeout_ticks <= 10'd240;
      cfg_r.reset_tail_ticks       <= 10'd490;
      cfg_r.write_one_low_ticks    <= 10'd5;
      cfg_r.write_one_high_ticks   <= 10'd45;
      cfg_r.write_zero_low_ticks   <= 10'd90;
      cfg_r.write_zero_high_ticks  <= 10'd10;
      cfg_r.read_recovery_ticks    <= 10'd80;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESET_LOW:   cfg_r.reset_low_ticks        <= cfg_data;
        REG_PRES_TMO:    cfg_r.presence_timeout_ticks <= cfg_data;
        REG_RESET_TAIL:  cfg_r.reset_tail_ticks       <= cfg_data;
        REG_WR1_LOW:     cfg_r.write_one_low_ticks    <= cfg_data;
        REG_WR1_HIGH:    cfg_r.write_one_high_ticks   <= cfg_data;
        REG_WR0_LOW:     cfg_r.write_zero_low_ticks   <= cfg_data;
        REG_WR0_HIGH:    cfg_r.write_zero_high_ticks  <= cfg_data;
        REG_RD_RECOVERY: cfg_r.read_recovery_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/owbm_seq.sv -----
// ----------------------------------------------------------------------------
// owbm_seq: bus sequencer
// Holds the phase, tick counter, bit index and shift byte, and works out the
// next state and the result word for one item in a single pass, including
// the skip over phases of zero length.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_seq
  import owbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      res
);

  phase_t     phase_r, phase_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [2:0] bidx_r, bidx_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic       pres_r, pres_nxt;
  logic [7:0] lrd_r, lrd_nxt;
  logic       done, rej, fin;

  cnt_t       cur_len;
  cnt_t       cnt_inc;
  logic       skip1, skip0;
  logic       hit;
  logic [2:0] kk;
  logic [3:0] span;

  // A write bit is skipped outright when both its phases are empty
  assign skip1 = (sat_len(cfg.write_one_low_ticks) == '0) &&
                 (sat_len(cfg.write_one_high_ticks) == '0);
  assign skip0 = (sat_len(cfg.write_zero_low_ticks) == '0) &&
                 (sat_len(cfg.write_zero_high_ticks) == '0);
  assign cnt_inc = cnt_r + cnt_t'(1);

  // Length of the phase in progress
  always_comb begin
    unique case (phase_r)
      PH_RST_LOW:  cur_len = sat_len(cfg.reset_low_ticks);
      PH_RST_WAIT: cur_len = sat_len(cfg.presence_timeout_ticks);
      PH_RST_TAIL: cur_len = sat_len(cfg.reset_tail_ticks);
      PH_WR_LOW:   cur_len = sh_r[0] ? sat_len(cfg.write_one_low_ticks)
                                     : sat_len(cfg.write_zero_low_ticks);
      PH_WR_HIGH:  cur_len = sh_r[0] ? sat_len(cfg.write_one_high_ticks)
                                     : sat_len(cfg.write_zero_high_ticks);
      PH_WR_GAP:   cur_len = GAP_LEN;
      PH_RD_LOW:   cur_len = READ_LOW_LEN;
      PH_RD_WAIT:  cur_len = READ_WAIT_LEN;
      PH_RD_REC:   cur_len = sat_len(cfg.read_recovery_ticks);
      default:     cur_len = '0;
    endcase
  end

  // Next state for one item
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bidx_nxt  = bidx_r;
    sh_nxt    = sh_r;
    pres_nxt  = pres_r;
    lrd_nxt   = lrd_r;
    done      = 1'b0;
    rej       = 1'b0;
    fin       = 1'b0;
    hit       = 1'b0;
    kk        = '0;
    span      = '0;

    // Start a command, or advance the running phase on a tick
    if (item.req_type != REQ_TICK) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        cnt_nxt  = '0;
        bidx_nxt = '0;
        case (item.req_type)
          REQ_RESET: begin
            pres_nxt  = 1'b0;
            sh_nxt    = '0;
            phase_nxt = PH_RST_LOW;
          end
          REQ_WRITE: begin
            sh_nxt    = item.write_data;
            phase_nxt = PH_WR_LOW;
          end
          default: begin
            sh_nxt    = '0;
            phase_nxt = PH_RD_LOW;
          end
        endcase
      end
    end else if (phase_r != PH_IDLE) begin
      if (phase_r == PH_RST_WAIT && !item.line_level) begin
        pres_nxt = 1'b1;
        fin      = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        fin     = (cnt_inc >= cur_len);
      end
      if (fin) begin
        cnt_nxt = '0;
        unique case (phase_r)
          PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
          PH_RST_WAIT: phase_nxt = PH_RST_TAIL;
          PH_WR_LOW:   phase_nxt = PH_WR_HIGH;
          PH_WR_HIGH: begin
            if (bidx_r == 3'd7) begin
              phase_nxt = PH_WR_GAP;
            end else begin
              bidx_nxt  = bidx_r + 3'd1;
              sh_nxt    = sh_r >> 1;
              phase_nxt = PH_WR_LOW;
            end
          end
          PH_RD_LOW:   phase_nxt = PH_RD_WAIT;
          PH_RD_WAIT: begin
            sh_nxt    = {item.line_level, sh_r[7:1]};
            phase_nxt = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (bidx_r == 3'd7) begin
              lrd_nxt   = sh_r;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              bidx_nxt  = bidx_r + 3'd1;
              phase_nxt = PH_RD_LOW;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end

    // Skip empty reset phases
    if (phase_nxt == PH_RST_LOW && sat_len(cfg.reset_low_ticks) == '0) begin
      phase_nxt = PH_RST_WAIT;
    end
    if (phase_nxt == PH_RST_WAIT && sat_len(cfg.presence_timeout_ticks) == '0) begin
      phase_nxt = PH_RST_TAIL;
    end
    if (phase_nxt == PH_RST_TAIL && sat_len(cfg.reset_tail_ticks) == '0) begin
      phase_nxt = PH_IDLE;
      done      = 1'b1;
    end

    // Skip an empty release phase of a write bit
    if (phase_nxt == PH_WR_HIGH &&
        (sh_nxt[0] ? sat_len(cfg.write_one_high_ticks)
                   : sat_len(cfg.write_zero_high_ticks)) == '0) begin
      if (bidx_nxt == 3'd7) begin
        phase_nxt = PH_WR_GAP;
      end else begin
        bidx_nxt  = bidx_nxt + 3'd1;
        sh_nxt    = sh_nxt >> 1;
        phase_nxt = PH_WR_LOW;
      end
    end

    // Find the first remaining write bit with a non-empty phase
    if (phase_nxt == PH_WR_LOW) begin
      for (int k = 7; k >= 0; k--) begin
        if (({1'b0, bidx_nxt} + 4'(k)) <= 4'd7 &&
            !(sh_nxt[k] ? skip1 : skip0)) begin
          hit = 1'b1;
          kk  = 3'(k);
        end
      end
      if (hit) begin
        bidx_nxt  = bidx_nxt + kk;
        sh_nxt    = sh_nxt >> kk;
        phase_nxt = ((sh_nxt[0] ? sat_len(cfg.write_one_low_ticks)
                                : sat_len(cfg.write_zero_low_ticks)) != '0)
                    ? PH_WR_LOW : PH_WR_HIGH;
      end else begin
        span      = 4'd7 - {1'b0, bidx_nxt};
        sh_nxt    = sh_nxt >> span;
        bidx_nxt  = 3'd7;
        phase_nxt = PH_WR_GAP;
      end
    end

    // Skip an empty byte gap
    if (phase_nxt == PH_WR_GAP && GAP_LEN == '0) begin
      phase_nxt = PH_IDLE;
      done      = 1'b1;
    end

    // Skip an empty read recovery
    if (phase_nxt == PH_RD_REC && sat_len(cfg.read_recovery_ticks) == '0) begin
      if (bidx_nxt == 3'd7) begin
        lrd_nxt   = sh_nxt;
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end else begin
        bidx_nxt  = bidx_nxt + 3'd1;
        phase_nxt = PH_RD_LOW;
      end
    end
  end

  // Result word for this item
  always_comb begin
    res.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                    (phase_nxt == PH_RD_LOW);
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = lrd_nxt;
    res.rejected  = rej;
  end

  // Commit state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bidx_r  <= '0;
      sh_r    <= '0;
      pres_r  <= 1'b0;
      lrd_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bidx_r  <= bidx_nxt;
      sh_r    <= sh_nxt;
      pres_r  <= pres_nxt;
      lrd_r   <= lrd_nxt;
    end
  end

  // A rejected command leaves the sequencer untouched
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rej) |=> ($stable(phase_r) && $stable(cnt_r) && $stable(bidx_r)))
    else $error("rejected command changed sequencer state");

  // Completion always lands in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && done) |=> (phase_r == PH_IDLE))
    else $error("operation completed but sequencer not idle");

  // The byte gap only follows the last bit
  a_gap_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WR_GAP) |-> (bidx_r == 3'd7))
    else $error("byte gap entered before the eighth bit");

  // Counter sits at zero while idle
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (cnt_r == '0))
    else $error("tick counter running while idle");

endmodule

`default_nettype wire
